### sv/aas_pkg.sv
// ----------------------------------------------------------------------------
// aas_pkg - shared types and constants of the add/subtract execute unit
// Request and response payloads, decoded queue entry, register file write
// bundle, action and operand codes.
// ----------------------------------------------------------------------------
package aas_pkg;

	// architectural sizes
	localparam int unsigned XLEN      = 64;
	localparam int unsigned NUM_REGS  = 31;
	localparam int unsigned REG_IDX_W = 5;
	localparam int unsigned IMM_W     = 12;
	localparam int unsigned IMM_SHIFT = 12;
	localparam int unsigned IMM_OP_W  = IMM_W + IMM_SHIFT;

	// index that means zero register or stack pointer
	localparam logic [REG_IDX_W-1:0] ZR_SP_IDX = 5'd31;

	// action codes
	localparam logic [2:0] ACT_IMM   = 3'd0;
	localparam logic [2:0] ACT_SHIFT = 3'd1;
	localparam logic [2:0] ACT_EXT   = 3'd2;
	localparam logic [2:0] ACT_CARRY = 3'd3;
	localparam logic [2:0] ACT_LOAD  = 3'd4;

	// shift kinds
	localparam logic [1:0] SHK_LSL  = 2'd0;
	localparam logic [1:0] SHK_LSR  = 2'd1;
	localparam logic [1:0] SHK_ASR  = 2'd2;
	localparam logic [1:0] SHK_ZERO = 2'd3;

	// extend options
	localparam logic [2:0] EXT_UXTB = 3'd0;
	localparam logic [2:0] EXT_UXTH = 3'd1;
	localparam logic [2:0] EXT_UXTW = 3'd2;
	localparam logic [2:0] EXT_UXTX = 3'd3;
	localparam logic [2:0] EXT_SXTB = 3'd4;
	localparam logic [2:0] EXT_SXTH = 3'd5;
	localparam logic [2:0] EXT_SXTW = 3'd6;
	localparam logic [2:0] EXT_SXTX = 3'd7;

	// nzcv bit positions
	localparam int unsigned FLG_N = 3;
	localparam int unsigned FLG_Z = 2;
	localparam int unsigned FLG_C = 1;
	localparam int unsigned FLG_V = 0;

	// response status codes
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_UNSUP = 1'b1;

	// class of a decoded request
	typedef enum logic [1:0] {
		CLS_EXEC,
		CLS_LOAD,
		CLS_UNSUP
	} cls_t;

	// source of the second operand
	typedef enum logic [1:0] {
		OPB_IMM,
		OPB_SHIFT,
		OPB_EXT,
		OPB_REG
	} opb_t;

	typedef struct packed {
		logic [2:0]           action;
		logic                 is_wide;
		logic                 is_subtract;
		logic                 sets_flags;
		logic [REG_IDX_W-1:0] dest_reg;
		logic [REG_IDX_W-1:0] first_reg;
		logic [REG_IDX_W-1:0] second_reg;
		logic [IMM_W-1:0]     immediate;
		logic [1:0]           shift_kind;
		logic [5:0]           shift_count;
		logic [2:0]           extend_option;
		logic [XLEN-1:0]      load_value;
	} req_t;

	typedef struct packed {
		logic                 status;
		logic [XLEN-1:0]      result_value;
		logic                 dest_written;
		logic [REG_IDX_W-1:0] dest_index;
		logic [3:0]           flags_out;
		logic [XLEN-1:0]      next_pc;
	} rsp_t;

	// decoded request as held in the queue
	typedef struct packed {
		cls_t                 cls;
		opb_t                 opb;
		logic                 is_wide;
		logic                 is_subtract;
		logic                 sets_flags;
		logic                 rn_sp;
		logic                 rn_zero;
		logic                 rm_zero;
		logic                 wr_reg;
		logic                 wr_sp;
		logic [REG_IDX_W-1:0] dest_reg;
		logic [REG_IDX_W-1:0] first_reg;
		logic [REG_IDX_W-1:0] second_reg;
		logic [IMM_OP_W-1:0]  imm_op;
		logic [1:0]           shift_kind;
		logic [5:0]           shift_count;
		logic [2:0]           extend_option;
		logic [XLEN-1:0]      load_value;
	} dec_t;

	// register file write bundle
	typedef struct packed {
		logic                 en;
		logic [REG_IDX_W-1:0] idx;
		logic [XLEN-1:0]      data;
	} wr_t;

endpackage

### sv/arm64_add_sub_execute.sv
// ----------------------------------------------------------------------------
// arm64_add_sub_execute - 64-bit add/subtract execute unit
// Front end with decode, request queue and back end that executes against
// the register file, stack pointer, nzcv flags and program counter.
// ----------------------------------------------------------------------------
// The unit takes one request per cycle while the queue has room and returns
// one response per request, in order. An accepted request waits in the queue,
// moves into the execute stage as the registered register file read starts,
// and passes from the execute stage into the output register. The execute
// stage, a single adder with operand shifter, sets the sustained rate of one
// request per cycle while responses are not stalled; the queue (QUEUE_DEPTH
// entries, at least two) lets requests keep coming while a response is held
// by stall. The register file sits in two rams, one per source port, with a
// valid bit per entry, so it reads as zero after reset with no clearing pass.
// ----------------------------------------------------------------------------
module arm64_add_sub_execute #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  aas_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output aas_pkg::rsp_t rsp
);

	logic          q_full;
	logic          push;
	aas_pkg::dec_t push_data;
	logic          pop;
	logic          head_valid;
	aas_pkg::dec_t head;

	// intake and classification
	aas_front u_front (
		.req_valid (req_valid),
		.req       (req),
		.req_stall (req_stall),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	// decoupling queue
	aas_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// execution
	aas_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

endmodule

### sv/aas_ram.sv
// ----------------------------------------------------------------------------
// aas_ram - generic single write, single read ram
// One write port and one read port with registered read data; a read in the
// cycle of a write to the same address returns the old contents.
// ----------------------------------------------------------------------------
module aas_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 31
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/aas_front.sv
// ----------------------------------------------------------------------------
// aas_front - request intake and classification
// Accepts requests while the queue has room and turns each into a decoded
// entry: class, second operand source, index 31 handling and write targets.
// ----------------------------------------------------------------------------
module aas_front (
	input  logic          req_valid,
	input  aas_pkg::req_t req,
	output logic          req_stall,
	input  logic          q_full,
	output logic          push,
	output aas_pkg::dec_t push_data
);

	logic sp_form;
	logic rn31;
	logic rd31;

	// accept whenever the queue has a free slot
	assign req_stall = q_full;
	assign push      = req_valid && !q_full;

	// classify the request
	always_comb begin
		push_data = '0;
		sp_form   = 1'b0;
		rn31      = (req.first_reg == aas_pkg::ZR_SP_IDX);
		rd31      = (req.dest_reg == aas_pkg::ZR_SP_IDX);

		push_data.is_wide       = req.is_wide;
		push_data.is_subtract   = req.is_subtract;
		push_data.sets_flags    = req.sets_flags;
		push_data.dest_reg      = req.dest_reg;
		push_data.first_reg     = req.first_reg;
		push_data.second_reg    = req.second_reg;
		push_data.shift_kind    = req.shift_kind;
		push_data.shift_count   = req.shift_count;
		push_data.extend_option = req.extend_option;
		push_data.load_value    = req.load_value;

		case (req.action)
			aas_pkg::ACT_IMM: begin
				push_data.cls = aas_pkg::CLS_EXEC;
				push_data.opb = aas_pkg::OPB_IMM;
				sp_form       = 1'b1;
			end
			aas_pkg::ACT_SHIFT: begin
				push_data.cls = aas_pkg::CLS_EXEC;
				push_data.opb = aas_pkg::OPB_SHIFT;
			end
			aas_pkg::ACT_EXT: begin
				push_data.cls = aas_pkg::CLS_EXEC;
				push_data.opb = aas_pkg::OPB_EXT;
				sp_form       = 1'b1;
			end
			aas_pkg::ACT_CARRY: begin
				push_data.cls = aas_pkg::CLS_EXEC;
				push_data.opb = aas_pkg::OPB_REG;
			end
			aas_pkg::ACT_LOAD: begin
				push_data.cls = aas_pkg::CLS_LOAD;
				push_data.opb = aas_pkg::OPB_REG;
			end
			default: begin
				push_data.cls = aas_pkg::CLS_UNSUP;
				push_data.opb = aas_pkg::OPB_REG;
			end
		endcase

		// immediate operand, optionally moved up by twelve
		if (req.shift_kind != aas_pkg::SHK_LSL) begin
			push_data.imm_op = {req.immediate, aas_pkg::IMM_SHIFT'(0)};
		end else begin
			push_data.imm_op = {aas_pkg::IMM_SHIFT'(0), req.immediate};
		end

		// index 31 as a source
		push_data.rn_sp   = sp_form && !req.sets_flags && rn31;
		push_data.rn_zero = rn31 && !push_data.rn_sp;
		push_data.rm_zero = (req.second_reg == aas_pkg::ZR_SP_IDX);

		// write targets
		if (push_data.cls == aas_pkg::CLS_LOAD) begin
			push_data.wr_reg = !rd31;
			push_data.wr_sp  = rd31;
		end else if (push_data.cls == aas_pkg::CLS_EXEC) begin
			push_data.wr_reg = !rd31;
			push_data.wr_sp  = rd31 && sp_form && !req.sets_flags;
		end
	end

endmodule

### sv/aas_queue.sv
// ----------------------------------------------------------------------------
// aas_queue - decoded request queue
// Short first-in first-out buffer of decoded entries between the front and
// the back; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module aas_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  aas_pkg::dec_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output aas_pkg::dec_t head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	aas_pkg::dec_t    entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### sv/aas_back.sv
// ----------------------------------------------------------------------------
// aas_back - execute part
// Reads operands from the register file rams, shifts or extends the second
// operand, adds, updates registers, stack pointer, flags and program counter,
// and holds the response in an output register.
// ----------------------------------------------------------------------------
module aas_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  aas_pkg::dec_t head,
	output logic          pop,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output aas_pkg::rsp_t rsp
);

	localparam int unsigned XLEN = aas_pkg::XLEN;
	localparam int unsigned NREG = aas_pkg::NUM_REGS;
	localparam int unsigned IDXW = aas_pkg::REG_IDX_W;

	// execute stage and output register
	logic          ex_valid_s1;
	aas_pkg::dec_t ex_s1;
	logic          rsp_valid_q;
	aas_pkg::rsp_t rsp_q;
	logic          ex_fire;

	// architectural state
	logic [XLEN-1:0] sp_q;
	logic [3:0]      flags_q;
	logic [XLEN-1:0] pc_q;
	logic [NREG-1:0] reg_valid_q;

	// most recent register file write, for the ram read-during-write gap
	logic            fwd_valid_q;
	logic [IDXW-1:0] fwd_idx_q;
	logic [XLEN-1:0] fwd_data_q;

	// datapath
	logic [XLEN-1:0] rdata_a;
	logic [XLEN-1:0] rdata_b;
	logic [XLEN-1:0] reg_a;
	logic [XLEN-1:0] reg_b;
	logic [XLEN-1:0] rn_val;
	logic [XLEN-1:0] rm_val;
	logic [XLEN-1:0] mask;
	logic [XLEN-1:0] sh_in;
	logic [XLEN-1:0] sh_sext;
	logic            sh_over;
	logic [5:0]      asr_amt;
	logic [XLEN-1:0] shifted;
	logic [XLEN-1:0] extended;
	logic [XLEN-1:0] ext_sh;
	logic [XLEN-1:0] right;
	logic [XLEN-1:0] left;
	logic [XLEN-1:0] addend;
	logic            cin;
	logic [XLEN:0]   sum;
	logic [XLEN-1:0] res;
	logic            carry;
	logic            sgn_l;
	logic            sgn_a;
	logic            sgn_r;
	logic [3:0]      new_flags;

	// update of state and response
	aas_pkg::wr_t    wr;
	logic            sp_we;
	logic [XLEN-1:0] sp_nxt;
	logic [3:0]      flags_nxt;
	logic [XLEN-1:0] pc_nxt;
	aas_pkg::rsp_t   rsp_nxt;

	// flow control
	assign ex_fire   = ex_valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign pop       = head_valid && (!ex_valid_s1 || ex_fire);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// register file, one copy per read port
	aas_ram #(
		.WIDTH (XLEN),
		.DEPTH (NREG)
	) u_ram_a (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.idx),
		.wdata (wr.data),
		.re    (pop),
		.raddr (head.first_reg),
		.rdata (rdata_a)
	);

	aas_ram #(
		.WIDTH (XLEN),
		.DEPTH (NREG)
	) u_ram_b (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.idx),
		.wdata (wr.data),
		.re    (pop),
		.raddr (head.second_reg),
		.rdata (rdata_b)
	);

	// operand fetch: latest write, then ram, unwritten entries read zero
	always_comb begin
		if (fwd_valid_q && (fwd_idx_q == ex_s1.first_reg)) begin
			reg_a = fwd_data_q;
		end else if (reg_valid_q[ex_s1.first_reg]) begin
			reg_a = rdata_a;
		end else begin
			reg_a = '0;
		end
		if (fwd_valid_q && (fwd_idx_q == ex_s1.second_reg)) begin
			reg_b = fwd_data_q;
		end else if (reg_valid_q[ex_s1.second_reg]) begin
			reg_b = rdata_b;
		end else begin
			reg_b = '0;
		end

		if (ex_s1.rn_sp) begin
			rn_val = sp_q;
		end else if (ex_s1.rn_zero) begin
			rn_val = '0;
		end else begin
			rn_val = reg_a;
		end
		rm_val = ex_s1.rm_zero ? '0 : reg_b;
	end

	assign mask = {{32{ex_s1.is_wide}}, 32'hFFFF_FFFF};

	// shifted register operand
	always_comb begin
		sh_in   = rm_val & mask;
		sh_over = !ex_s1.is_wide && ex_s1.shift_count[5];
		asr_amt = sh_over ? 6'd31 : ex_s1.shift_count;
		sh_sext = ex_s1.is_wide ? sh_in : {{32{sh_in[31]}}, sh_in[31:0]};
		case (ex_s1.shift_kind)
			aas_pkg::SHK_LSL: shifted = sh_over ? '0 : (sh_in << ex_s1.shift_count);
			aas_pkg::SHK_LSR: shifted = sh_over ? '0 : (sh_in >> ex_s1.shift_count);
			aas_pkg::SHK_ASR: shifted = $unsigned($signed(sh_sext) >>> asr_amt);
			default:          shifted = '0;
		endcase
	end

	// extended register operand
	always_comb begin
		case (ex_s1.extend_option)
			aas_pkg::EXT_UXTB: extended = {56'b0, rm_val[7:0]};
			aas_pkg::EXT_UXTH: extended = {48'b0, rm_val[15:0]};
			aas_pkg::EXT_UXTW: extended = {32'b0, rm_val[31:0]};
			aas_pkg::EXT_UXTX: extended = rm_val;
			aas_pkg::EXT_SXTB: extended = {{56{rm_val[7]}}, rm_val[7:0]};
			aas_pkg::EXT_SXTH: extended = {{48{rm_val[15]}}, rm_val[15:0]};
			aas_pkg::EXT_SXTW: extended = {{32{rm_val[31]}}, rm_val[31:0]};
			aas_pkg::EXT_SXTX: extended = rm_val;
			default:           extended = rm_val;
		endcase
		ext_sh = extended << ex_s1.shift_count;
	end

	// adder and flags
	always_comb begin
		case (ex_s1.opb)
			aas_pkg::OPB_IMM:   right = XLEN'(ex_s1.imm_op);
			aas_pkg::OPB_SHIFT: right = shifted;
			aas_pkg::OPB_EXT:   right = ext_sh;
			aas_pkg::OPB_REG:   right = rm_val;
			default:            right = rm_val;
		endcase
		left   = rn_val & mask;
		addend = (ex_s1.is_subtract ? ~right : right) & mask;
		cin    = (ex_s1.opb == aas_pkg::OPB_REG) ? flags_q[aas_pkg::FLG_C] : ex_s1.is_subtract;
		sum    = {1'b0, left} + {1'b0, addend} + (XLEN+1)'(cin);
		res    = sum[XLEN-1:0] & mask;
		carry  = ex_s1.is_wide ? sum[XLEN] : sum[32];
		sgn_l  = ex_s1.is_wide ? left[XLEN-1] : left[31];
		sgn_a  = ex_s1.is_wide ? addend[XLEN-1] : addend[31];
		sgn_r  = ex_s1.is_wide ? res[XLEN-1] : res[31];

		new_flags                = '0;
		new_flags[aas_pkg::FLG_N] = sgn_r;
		new_flags[aas_pkg::FLG_Z] = (res == '0);
		new_flags[aas_pkg::FLG_C] = carry;
		new_flags[aas_pkg::FLG_V] = (sgn_l == sgn_a) && (sgn_l != sgn_r);
	end

	// outcome per class
	always_comb begin
		wr        = '0;
		sp_we     = 1'b0;
		sp_nxt    = sp_q;
		flags_nxt = flags_q;
		pc_nxt    = pc_q;
		rsp_nxt   = '0;
		wr.idx    = ex_s1.dest_reg;

		case (ex_s1.cls)
			aas_pkg::CLS_EXEC: begin
				wr.en     = ex_s1.wr_reg;
				wr.data   = res;
				sp_we     = ex_s1.wr_sp;
				sp_nxt    = res;
				flags_nxt = ex_s1.sets_flags ? new_flags : flags_q;
				pc_nxt    = pc_q + XLEN'(4);
				rsp_nxt.status       = aas_pkg::STATUS_OK;
				rsp_nxt.result_value = res;
				rsp_nxt.dest_written = ex_s1.wr_reg || ex_s1.wr_sp;
				rsp_nxt.dest_index   = ex_s1.dest_reg;
			end
			aas_pkg::CLS_LOAD: begin
				wr.en     = ex_s1.wr_reg;
				wr.data   = ex_s1.load_value;
				sp_we     = ex_s1.wr_sp;
				sp_nxt    = ex_s1.load_value;
				rsp_nxt.status       = aas_pkg::STATUS_OK;
				rsp_nxt.result_value = ex_s1.load_value;
				rsp_nxt.dest_written = 1'b1;
				rsp_nxt.dest_index   = ex_s1.dest_reg;
			end
			default: begin
				rsp_nxt.status = aas_pkg::STATUS_UNSUP;
			end
		endcase
		rsp_nxt.flags_out = flags_nxt;
		rsp_nxt.next_pc   = pc_nxt;

		// commit only when the request leaves the execute stage
		wr.en = wr.en && ex_fire;
		sp_we = sp_we && ex_fire;
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ex_valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
			sp_q        <= '0;
			flags_q     <= '0;
			pc_q        <= '0;
			reg_valid_q <= '0;
			fwd_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				ex_valid_s1 <= 1'b1;
			end else if (ex_fire) begin
				ex_valid_s1 <= 1'b0;
			end
			if (ex_fire) begin
				rsp_valid_q <= 1'b1;
				flags_q     <= flags_nxt;
				pc_q        <= pc_nxt;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (sp_we) begin
				sp_q <= sp_nxt;
			end
			if (wr.en) begin
				reg_valid_q[wr.idx] <= 1'b1;
				fwd_valid_q         <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pop) begin
			ex_s1 <= head;
		end
		if (ex_fire) begin
			rsp_q <= rsp_nxt;
		end
		if (wr.en) begin
			fwd_idx_q  <= wr.idx;
			fwd_data_q <= wr.data;
		end
	end

endmodule

### sv/aas_checker.sv
// ----------------------------------------------------------------------------
// aas_checker - port level checks of the execute unit
// Watches the response channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
module aas_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input aas_pkg::rsp_t rsp
);

	logic        rsp_acc;
	logic [63:0] last_pc_q;
	logic [3:0]  last_flags_q;

	assign rsp_acc = rsp_valid && !rsp_stall;

	// state reported by the last delivered response, zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pc_q    <= '0;
			last_flags_q <= '0;
		end else begin
			if (rsp_acc) begin
				last_pc_q    <= rsp.next_pc;
				last_flags_q <= rsp.flags_out;
			end
		end
	end

	// a held response stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// unsupported requests report nothing written
	a_unsup_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == aas_pkg::STATUS_UNSUP) |->
		(rsp.result_value == '0) && !rsp.dest_written && (rsp.dest_index == '0))
		else $error("unsupported response carries a result");

	// a discarded result only ever targets index 31
	a_discard_idx: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == aas_pkg::STATUS_OK) && !rsp.dest_written |->
		(rsp.dest_index == aas_pkg::ZR_SP_IDX))
		else $error("result discarded for an ordinary register");

	// program counter holds or steps by four between responses
	a_pc_step: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_acc |-> (rsp.next_pc == last_pc_q) || (rsp.next_pc == last_pc_q + 64'd4))
		else $error("program counter jumped");

	// unsupported requests leave flags and program counter alone
	a_unsup_state: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_acc && (rsp.status == aas_pkg::STATUS_UNSUP) |->
		(rsp.flags_out == last_flags_q) && (rsp.next_pc == last_pc_q))
		else $error("unsupported request changed state");

endmodule

bind arm64_add_sub_execute aas_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

### tb/sv/arm64_add_sub_execute_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// arm64_add_sub_execute_tb - self-checking bench of the add/subtract unit
// Keeps its own copy of the register file, stack pointer, nzcv flags and
// program counter, works out the response of every accepted request and
// compares each response field by field, in order. Directed requests on the
// extreme cases come first, then a long random mix with random idling on the
// request side and random stall on the response side.
// ----------------------------------------------------------------------------

// architectural shadow of the unit and the responses still owed by it
class add_sub_tracker;
	logic [63:0]   gpr [0:30];
	logic [63:0]   sp_q;
	logic [63:0]   pc_q;
	logic [3:0]    nzcv;
	aas_pkg::rsp_t pending_results [$];
	int            errors;

	function new();
		foreach (gpr[i]) gpr[i] = '0;
		sp_q   = '0;
		pc_q   = '0;
		nzcv   = '0;
		errors = 0;
	endfunction

	function int pending();
		return pending_results.size();
	endfunction

	// index 31 reads as zero
	function logic [63:0] read_zr(logic [4:0] idx);
		return (idx == aas_pkg::ZR_SP_IDX) ? 64'd0 : gpr[idx];
	endfunction

	// index 31 reads the stack pointer
	function logic [63:0] read_sp(logic [4:0] idx);
		return (idx == aas_pkg::ZR_SP_IDX) ? sp_q : gpr[idx];
	endfunction

	// second operand of the shifted register form, within the operation width
	function logic [63:0] shifted_operand(logic [63:0] raw, logic wide, logic [1:0] kind,
		logic [5:0] amt);
		logic [63:0]        mask;
		logic [63:0]        v;
		logic [63:0]        sext;
		logic signed [63:0] ashr;
		int unsigned        bits;
		int unsigned        asr_by;
		mask = wide ? '1 : 64'h0000_0000_ffff_ffff;
		bits = wide ? 64 : 32;
		v    = raw & mask;
		sext = wide ? v : {{32{v[31]}}, v[31:0]};
		case (kind)
			aas_pkg::SHK_LSL: return (amt >= bits) ? 64'd0 : ((v << amt) & mask);
			aas_pkg::SHK_LSR: return (amt >= bits) ? 64'd0 : (v >> amt);
			aas_pkg::SHK_ASR: begin
				// distances past the width keep filling with the sign
				asr_by = (amt >= bits) ? bits - 1 : amt;
				ashr   = $signed(sext) >>> asr_by;
				return ashr & mask;
			end
			default: return 64'd0;
		endcase
	endfunction

	// second operand of the extended register form before its shift
	function logic [63:0] extended_operand(logic [63:0] v, logic [2:0] opt);
		case (opt)
			aas_pkg::EXT_UXTB: return {56'd0, v[7:0]};
			aas_pkg::EXT_UXTH: return {48'd0, v[15:0]};
			aas_pkg::EXT_UXTW: return {32'd0, v[31:0]};
			aas_pkg::EXT_SXTB: return {{56{v[7]}}, v[7:0]};
			aas_pkg::EXT_SXTH: return {{48{v[15]}}, v[15:0]};
			aas_pkg::EXT_SXTW: return {{32{v[31]}}, v[31:0]};
			default:           return v;
		endcase
	endfunction

	// run one request against the shadow state and return its response
	function aas_pkg::rsp_t execute_instr(aas_pkg::req_t r);
		aas_pkg::rsp_t o;
		logic [63:0]   mask;
		logic [63:0]   left;
		logic [63:0]   right;
		logic [63:0]   addend;
		logic [63:0]   res;
		logic [64:0]   sum;
		logic          cin;
		logic          carry;
		logic          sp_form;
		logic          written;
		int unsigned   sb;
		mask        = r.is_wide ? '1 : 64'h0000_0000_ffff_ffff;
		sb          = r.is_wide ? 63 : 31;
		o           = '0;
		o.flags_out = nzcv;
		o.next_pc   = pc_q;

		// register seeding leaves flags and pc alone
		if (r.action == aas_pkg::ACT_LOAD) begin
			if (r.dest_reg == aas_pkg::ZR_SP_IDX) sp_q = r.load_value;
			else gpr[r.dest_reg] = r.load_value;
			o.status       = aas_pkg::STATUS_OK;
			o.result_value = r.load_value;
			o.dest_written = 1'b1;
			o.dest_index   = r.dest_reg;
			return o;
		end
		if (r.action > aas_pkg::ACT_LOAD) begin
			o.status = aas_pkg::STATUS_UNSUP;
			return o;
		end

		// operand selection per form
		cin     = r.is_subtract;
		sp_form = (r.action == aas_pkg::ACT_IMM) || (r.action == aas_pkg::ACT_EXT);
		left    = (sp_form && !r.sets_flags) ? read_sp(r.first_reg) : read_zr(r.first_reg);
		case (r.action)
			aas_pkg::ACT_IMM: begin
				right = (r.shift_kind != aas_pkg::SHK_LSL) ? {40'd0, r.immediate, 12'd0}
					: {52'd0, r.immediate};
			end
			aas_pkg::ACT_SHIFT: begin
				right = shifted_operand(read_zr(r.second_reg), r.is_wide, r.shift_kind,
					r.shift_count);
			end
			aas_pkg::ACT_EXT: begin
				right = extended_operand(read_zr(r.second_reg), r.extend_option)
					<< r.shift_count;
			end
			default: begin
				right = read_zr(r.second_reg);
				cin   = nzcv[aas_pkg::FLG_C];
			end
		endcase

		// add with inverted operand for subtract
		left   = left & mask;
		addend = (r.is_subtract ? ~right : right) & mask;
		sum    = {1'b0, left} + {1'b0, addend} + {64'd0, cin};
		carry  = r.is_wide ? sum[64] : sum[32];
		res    = sum[63:0] & mask;

		if (r.sets_flags) begin
			nzcv[aas_pkg::FLG_N] = res[sb];
			nzcv[aas_pkg::FLG_Z] = (res == 64'd0);
			nzcv[aas_pkg::FLG_C] = carry;
			nzcv[aas_pkg::FLG_V] = (left[sb] == addend[sb]) && (left[sb] != res[sb]);
		end

		// index 31 as destination: stack pointer or dropped
		written = 1'b1;
		if (r.dest_reg == aas_pkg::ZR_SP_IDX) begin
			if (sp_form && !r.sets_flags) sp_q = res;
			else written = 1'b0;
		end else begin
			gpr[r.dest_reg] = res;
		end
		pc_q = pc_q + 64'd4;

		o.status       = aas_pkg::STATUS_OK;
		o.result_value = res;
		o.dest_written = written;
		o.dest_index   = r.dest_reg;
		o.flags_out    = nzcv;
		o.next_pc      = pc_q;
		return o;
	endfunction

	function void note_request(aas_pkg::req_t r);
		pending_results.push_back(execute_instr(r));
	endfunction

	function void compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			if (errors < 40)
				$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			errors++;
		end
	endfunction

	function void check_response(aas_pkg::rsp_t got);
		aas_pkg::rsp_t want;
		if (pending_results.size() == 0) begin
			if (errors < 40)
				$display("%0t: response with none expected, expected none actual %h",
					$time, got);
			errors++;
			return;
		end
		want = pending_results.pop_front();
		compare_field("status", 64'(want.status), 64'(got.status));
		compare_field("result_value", want.result_value, got.result_value);
		compare_field("dest_written", 64'(want.dest_written), 64'(got.dest_written));
		compare_field("dest_index", 64'(want.dest_index), 64'(got.dest_index));
		compare_field("flags_out", 64'(want.flags_out), 64'(got.flags_out));
		compare_field("next_pc", want.next_pc, got.next_pc);
	endfunction
endclass

module arm64_add_sub_execute_tb;

	// action codes outside the supported set
	localparam logic [2:0] ACT_UNSUP_LO = 3'd5;
	localparam logic [2:0] ACT_UNSUP_HI = 3'd7;

	localparam int unsigned RANDOM_ITEMS = 750;
	localparam int unsigned MAX_GAP      = 12;
	localparam int unsigned IDLE_LIMIT   = 2000;
	localparam int unsigned TAIL_CYCLES  = 8;

	logic          clk;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_stall;
	aas_pkg::req_t req       = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	aas_pkg::rsp_t rsp;
	bit            calm      = 1'b0;
	int unsigned   idle_cycles = 0;

	add_sub_tracker book = new();

	wire req_fire = req_valid && !req_stall;
	wire rsp_fire = rsp_valid && !rsp_stall;

	arm64_add_sub_execute dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// 100 MHz clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic aas_pkg::req_t instr(logic [2:0] act, logic wide, logic sub,
		logic setf, logic [4:0] rd, logic [4:0] rn, logic [4:0] rm, logic [11:0] imm,
		logic [1:0] kind, logic [5:0] amt, logic [2:0] opt, logic [63:0] val);
		aas_pkg::req_t r;
		r.action        = act;
		r.is_wide       = wide;
		r.is_subtract   = sub;
		r.sets_flags    = setf;
		r.dest_reg      = rd;
		r.first_reg     = rn;
		r.second_reg    = rm;
		r.immediate     = imm;
		r.shift_kind    = kind;
		r.shift_count   = amt;
		r.extend_option = opt;
		r.load_value    = val;
		return r;
	endfunction

	// mostly a few hot registers so results feed later requests
	function automatic logic [4:0] pick_reg();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 15) return aas_pkg::ZR_SP_IDX;
		if (p < 75) return 5'($urandom_range(0, 7));
		return 5'($urandom_range(0, 30));
	endfunction

	function automatic aas_pkg::req_t rand_request();
		aas_pkg::req_t r;
		int unsigned   p;
		r               = '0;
		p               = $urandom_range(0, 99);
		r.is_wide       = 1'($urandom_range(0, 1));
		r.is_subtract   = 1'($urandom_range(0, 1));
		r.sets_flags    = 1'($urandom_range(0, 1));
		r.dest_reg      = pick_reg();
		r.first_reg     = pick_reg();
		r.second_reg    = pick_reg();
		r.immediate     = 12'($urandom);
		r.shift_kind    = 2'($urandom);
		r.extend_option = 3'($urandom);
		case ($urandom_range(0, 5))
			0:       r.shift_count = 6'd0;
			1:       r.shift_count = 6'd31;
			2:       r.shift_count = 6'd32;
			3:       r.shift_count = 6'd63;
			default: r.shift_count = 6'($urandom);
		endcase
		case ($urandom_range(0, 7))
			0:       r.load_value = '0;
			1:       r.load_value = '1;
			2:       r.load_value = 64'h8000_0000_0000_0000;
			3:       r.load_value = 64'h7fff_ffff_ffff_ffff;
			4:       r.load_value = 64'h0000_0000_8000_0000;
			5:       r.load_value = 64'h0000_0000_ffff_ffff;
			default: r.load_value = {$urandom, $urandom};
		endcase
		if (p < 12) begin
			r.action = aas_pkg::ACT_LOAD;
		end else if (p < 17) begin
			r.action = 3'($urandom_range(ACT_UNSUP_LO, ACT_UNSUP_HI));
		end else begin
			case ($urandom_range(0, 3))
				0:       r.action = aas_pkg::ACT_IMM;
				1:       r.action = aas_pkg::ACT_SHIFT;
				2:       r.action = aas_pkg::ACT_EXT;
				default: r.action = aas_pkg::ACT_CARRY;
			endcase
		end
		return r;
	endfunction

	// present one request after a random gap and hold it until taken
	task automatic issue(input aas_pkg::req_t r);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall);
	endtask

	// stop sending until every response has come back
	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (book.pending() != 0);
	endtask

	// response side stall, drawn afresh for every response
	initial begin
		int unsigned hold;
		do @(posedge clk); while (!arst_n);
		forever begin
			hold = calm ? 0 : $urandom_range(0, MAX_GAP);
			if (hold != 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	// accepted requests and responses
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_fire) book.note_request(req);
			if (rsp_fire) book.check_response(rsp);
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_fire || rsp_fire) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("[arm64_add_sub_execute] ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// seed registers and the stack pointer with edge values
		issue(instr(aas_pkg::ACT_LOAD, 1'b1, 1'b0, 1'b0, 5'd1, 5'd0, 5'd0,
			12'd0, aas_pkg::SHK_LSL, 6'd0, aas_pkg::EXT_UXTB, 64'hffff_ffff_ffff_ffff));
		issue(instr(aas_pkg::ACT_LOAD, 1'b1, 1'b0, 1'b0, 5'd2, 5'd0, 5'd0,
			12'd0, aas_pkg::SHK_LSL, 6'd0, aas_pkg::EXT_UXTB, 64'h8000_0000_0000_0000));
		issue(instr(aas_pkg::ACT_LOAD, 1'b1, 1'b0, 1'b0, 5'd3, 5'd0, 5'd0,
			12'd0, aas_pkg::SHK_LSL, 6'd0, aas_pkg::EXT_UXTB, 64'h0000_0000_7fff_ffff));
		issue(instr(aas_pkg::ACT_LOAD, 1'b1, 1'b0, 1'b0, 5'd4, 5'd0, 5'd0,
			12'd0, aas_pkg::SHK_LSL, 6'd0, aas_pkg::EXT_UXTB, 64'hffff_ffff_8000_0000));
		issue(instr(aas_pkg::ACT_LOAD, 1'b1, 1'b0, 1'b0, aas_pkg::ZR_SP_IDX, 5'd0, 5'd0,
			12'd0, aas_pkg::SHK_LSL, 6'd0, aas_pkg::EXT_UXTB, 64'h0000_0000_0000_1000));

		// immediate form: sp to sp with shifted max immediate, carry out, zero register
		issue(instr(aas_pkg::ACT_IMM, 1'b1, 1'b0, 1'b0, aas_pkg::ZR_SP_IDX,
			aas_pkg::ZR_SP_IDX, 5'd0,
			12'hfff, aas_pkg::SHK_LSR, 6'd0, aas_pkg::EXT_UXTB, '0));
		issue(instr(aas_pkg::ACT_IMM, 1'b1, 1'b0, 1'b1, 5'd5, 5'd1, 5'd0,
			12'd1, aas_pkg::SHK_LSL, 6'd0, aas_pkg::EXT_UXTB, '0));
		issue(instr(aas_pkg::ACT_IMM, 1'b0, 1'b1, 1'b1, 5'd6, aas_pkg::ZR_SP_IDX, 5'd0,
			12'd0, aas_pkg::SHK_LSL, 6'd0, aas_pkg::EXT_UXTB, '0));
		issue(instr(aas_pkg::ACT_IMM, 1'b0, 1'b1, 1'b0, 5'd7, aas_pkg::ZR_SP_IDX, 5'd0,
			12'd1, aas_pkg::SHK_ZERO, 6'd0, aas_pkg::EXT_UXTB, '0));

		// shifted register form: overflow, shifts at and past the width
		issue(instr(aas_pkg::ACT_SHIFT, 1'b1, 1'b0, 1'b1, 5'd8, 5'd2, 5'd2,
			12'd0, aas_pkg::SHK_LSL, 6'd0, aas_pkg::EXT_UXTB, '0));
		issue(instr(aas_pkg::ACT_SHIFT, 1'b0, 1'b1, 1'b1, 5'd9, 5'd3, 5'd4,
			12'd0, aas_pkg::SHK_LSL, 6'd0, aas_pkg::EXT_UXTB, '0));
		issue(instr(aas_pkg::ACT_SHIFT, 1'b1, 1'b0, 1'b0, 5'd10, 5'd1, 5'd1,
			12'd0, aas_pkg::SHK_LSR, 6'd63, aas_pkg::EXT_UXTB, '0));
		issue(instr(aas_pkg::ACT_SHIFT, 1'b1, 1'b0, 1'b0, 5'd11, aas_pkg::ZR_SP_IDX, 5'd2,
			12'd0, aas_pkg::SHK_ASR, 6'd63, aas_pkg::EXT_UXTB, '0));
		issue(instr(aas_pkg::ACT_SHIFT, 1'b0, 1'b0, 1'b1, 5'd12, 5'd3, 5'd4,
			12'd0, aas_pkg::SHK_ASR, 6'd40, aas_pkg::EXT_UXTB, '0));
		issue(instr(aas_pkg::ACT_SHIFT, 1'b0, 1'b0, 1'b0, 5'd13, 5'd1, 5'd1,
			12'd0, aas_pkg::SHK_LSL, 6'd32, aas_pkg::EXT_UXTB, '0));
		issue(instr(aas_pkg::ACT_SHIFT, 1'b1, 1'b1, 1'b1, aas_pkg::ZR_SP_IDX, 5'd1, 5'd1,
			12'd0, aas_pkg::SHK_ZERO, 6'd5, aas_pkg::EXT_UXTB, '0));

		// extended register form: sign extension, shift past bit 63, sp destination
		issue(instr(aas_pkg::ACT_EXT, 1'b1, 1'b0, 1'b0, 5'd14, aas_pkg::ZR_SP_IDX, 5'd1,
			12'd0, aas_pkg::SHK_LSL, 6'd0, aas_pkg::EXT_SXTB, '0));
		issue(instr(aas_pkg::ACT_EXT, 1'b0, 1'b1, 1'b1, 5'd15, 5'd3, 5'd4,
			12'd0, aas_pkg::SHK_LSL, 6'd4, aas_pkg::EXT_SXTW, '0));
		issue(instr(aas_pkg::ACT_EXT, 1'b1, 1'b0, 1'b0, aas_pkg::ZR_SP_IDX,
			aas_pkg::ZR_SP_IDX, 5'd3,
			12'd0, aas_pkg::SHK_LSL, 6'd63, aas_pkg::EXT_UXTH, '0));
		issue(instr(aas_pkg::ACT_EXT, 1'b1, 1'b1, 1'b1, 5'd16, 5'd2, 5'd1,
			12'd0, aas_pkg::SHK_LSL, 6'd1, aas_pkg::EXT_UXTX, '0));

		// with carry: add and subtract, discarded destination
		issue(instr(aas_pkg::ACT_CARRY, 1'b1, 1'b0, 1'b1, 5'd17, 5'd1, 5'd1,
			12'd0, aas_pkg::SHK_LSL, 6'd0, aas_pkg::EXT_UXTB, '0));
		issue(instr(aas_pkg::ACT_CARRY, 1'b0, 1'b1, 1'b1, 5'd18, 5'd3, 5'd4,
			12'd0, aas_pkg::SHK_LSL, 6'd0, aas_pkg::EXT_UXTB, '0));
		issue(instr(aas_pkg::ACT_CARRY, 1'b1, 1'b0, 1'b0, aas_pkg::ZR_SP_IDX,
			aas_pkg::ZR_SP_IDX, aas_pkg::ZR_SP_IDX,
			12'd0, aas_pkg::SHK_LSL, 6'd0, aas_pkg::EXT_UXTB, '0));

		// unsupported actions change nothing
		issue(instr(ACT_UNSUP_LO, 1'b0, 1'b0, 1'b0, 5'd0, 5'd0, 5'd0,
			12'd0, aas_pkg::SHK_LSL, 6'd0, aas_pkg::EXT_UXTB, '0));
		issue(instr(ACT_UNSUP_HI, 1'b1, 1'b1, 1'b1, aas_pkg::ZR_SP_IDX,
			aas_pkg::ZR_SP_IDX, aas_pkg::ZR_SP_IDX,
			12'hfff, aas_pkg::SHK_ZERO, 6'd63, aas_pkg::EXT_SXTX, '1));
		wait_drained();

		// random mix, idling switched off in some stretches
		for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 60 == 0) calm = ($urandom_range(0, 3) == 0);
			if (i == RANDOM_ITEMS / 2) wait_drained();
			issue(rand_request());
		end
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (book.errors == 0 && book.pending() == 0) begin
			$display("[arm64_add_sub_execute] OK");
		end else begin
			$display("[arm64_add_sub_execute] ERROR");
		end
		$finish;
	end

endmodule

### arm64_add_sub_execute.f
sv/aas_pkg.sv
sv/aas_ram.sv
sv/aas_front.sv
sv/aas_queue.sv
sv/aas_back.sv
sv/arm64_add_sub_execute.sv
sv/aas_checker.sv
tb/sv/arm64_add_sub_execute_tb.sv
